FILE: sv/nfn_pkg.sv
// Package for the Newell face normal block: field widths, item types and defaults.
package nfn_pkg;

  localparam int COORD_BITS      = 24;
  localparam int FACE_INDEX_BITS = 24;
  localparam int NORMAL_BITS     = 16;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int NORM_BITS       = 30;
  localparam int ACC_BITS        = 64;
  localparam int MUL_BITS        = 32;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic                         last_edge;
  } edge_item_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic [FACE_INDEX_BITS-1:0]    face_number;
    logic                          degenerate;
  } normal_item_t;

endpackage

FILE: sv/newell_face_normal.sv
// Top level of the Newell face normal block: edge accumulation and normalisation.

// Each edge item is accepted in the idle state; then one shared 32x32
// multiplier forms the three Newell cross terms in turn and a saturating
// 64-bit adder folds each into its sum in the following cycle. An edge that
// closes a face then runs the normalisation sequence on the same multiplier,
// followed by a bit-serial square root and a bit-serial divider. Before them
// the largest sum magnitude is brought into [2^29, 2^30) by single-bit shifts,
// up to 34 of them; a face whose sums are all zero skips the shifts, root and
// divider. The final state loads the output register and is held while an
// earlier result is still waiting there. The block takes no item while a face
// is normalised, but a finished result waits in its output register while the
// next face's edges are accumulated.
module newell_face_normal
  import nfn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  edge_item_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output normal_item_t result
);

  localparam int OUT_FRAC = OUT_FRAC_BITS;
  localparam int NUM_W = NORM_BITS + OUT_FRAC + 1;
  localparam int Q_W   = OUT_FRAC + 1;
  localparam int LEN_W = 32;
  localparam int REM_W = LEN_W + 1;
  localparam int DC_W  = $clog2(OUT_FRAC + 1) + 1;
  localparam logic [31:0] UNIT_Z = 32'd1 << OUT_FRAC;
  localparam logic [ACC_BITS-1:0] TOP_HI = ACC_BITS'(1) << NORM_BITS;
  localparam logic [ACC_BITS-1:0] TOP_LO = ACC_BITS'(1) << (NORM_BITS - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EDGE  = 10'b0000000010,
    S_MAG   = 10'b0000000100,
    S_TOP   = 10'b0000001000,
    S_SHIFT = 10'b0000010000,
    S_SQ    = 10'b0000100000,
    S_SQRT  = 10'b0001000000,
    S_DSET  = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  edge_item_t edge_r;
  logic [1:0] step;
  logic signed [ACC_BITS-1:0] sum_x, sum_y, sum_z;
  logic [FACE_INDEX_BITS-1:0] face_counter;
  logic signed [2*MUL_BITS-1:0] prod;
  logic [ACC_BITS-1:0] mx, my, mz, top, sumsq, sq_n, sq_r, sq_bit;
  logic [LEN_W-1:0] len;
  logic [REM_W-1:0] rem;
  logic [Q_W-1:0] dlow, quo;
  logic [DC_W-1:0] dcnt;
  logic [NORMAL_BITS-1:0] nx, ny, nz;
  logic degen;

  // Shared multiplier operands.
  logic signed [COORD_BITS:0] ta, tb;
  logic signed [MUL_BITS-1:0] mul_a, mul_b;
  logic [ACC_BITS-1:0] msq;

  always_comb begin
    case (step)
      2'd0: begin
        ta = {edge_r.start_y[COORD_BITS-1], edge_r.start_y} +
             {edge_r.end_y[COORD_BITS-1], edge_r.end_y};
        tb = {edge_r.end_z[COORD_BITS-1], edge_r.end_z} -
             {edge_r.start_z[COORD_BITS-1], edge_r.start_z};
        msq = mx;
      end
      2'd1: begin
        ta = {edge_r.start_z[COORD_BITS-1], edge_r.start_z} +
             {edge_r.end_z[COORD_BITS-1], edge_r.end_z};
        tb = {edge_r.end_x[COORD_BITS-1], edge_r.end_x} -
             {edge_r.start_x[COORD_BITS-1], edge_r.start_x};
        msq = my;
      end
      default: begin
        ta = {edge_r.start_x[COORD_BITS-1], edge_r.start_x} +
             {edge_r.end_x[COORD_BITS-1], edge_r.end_x};
        tb = {edge_r.end_y[COORD_BITS-1], edge_r.end_y} -
             {edge_r.start_y[COORD_BITS-1], edge_r.start_y};
        msq = mz;
      end
    endcase
    if (state == S_SQ) begin
      mul_a = {{(MUL_BITS - NORM_BITS){1'b0}}, msq[NORM_BITS-1:0]};
      mul_b = mul_a;
    end else begin
      mul_a = {{(MUL_BITS - COORD_BITS - 1){ta[COORD_BITS]}}, ta};
      mul_b = {{(MUL_BITS - COORD_BITS - 1){tb[COORD_BITS]}}, tb};
    end
  end

  // Saturating accumulation of the previous step's product.
  logic signed [ACC_BITS-1:0] acc_sel, acc_sat;
  logic [ACC_BITS:0] acc_wide;

  always_comb begin
    case (step)
      2'd1:    acc_sel = sum_x;
      2'd2:    acc_sel = sum_y;
      default: acc_sel = sum_z;
    endcase
    acc_wide = {acc_sel[ACC_BITS-1], acc_sel} + {prod[2*MUL_BITS-1], prod};
    if (acc_wide[ACC_BITS] != acc_wide[ACC_BITS-1]) begin
      acc_sat = acc_wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                   : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[ACC_BITS-1:0];
    end
  end

  // Square root step, divider setup and divider step.
  logic [ACC_BITS-1:0] sq_try;
  logic [ACC_BITS-1:0] m_sel;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] rem_sh;
  logic [Q_W-1:0] quo_next;
  logic [31:0] q_ext, q_signed;
  logic q_neg;

  always_comb begin
    sq_try = sq_r + sq_bit;
    case (step)
      2'd0:    begin m_sel = mx; q_neg = sum_x[ACC_BITS-1]; end
      2'd1:    begin m_sel = my; q_neg = sum_y[ACC_BITS-1]; end
      default: begin m_sel = mz; q_neg = sum_z[ACC_BITS-1]; end
    endcase
    num = (NUM_W'(m_sel[NORM_BITS-1:0]) << OUT_FRAC) + NUM_W'(len >> 1);
    rem_sh = {rem[REM_W-2:0], dlow[Q_W-1]};
    quo_next = {quo[Q_W-2:0], (rem_sh >= REM_W'(len))};
    q_ext = 32'(quo_next);
    q_signed = q_neg ? (32'd0 - q_ext) : q_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= 2'd0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      face_counter <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            edge_r <= item;
            step   <= 2'd0;
            state  <= S_EDGE;
          end
        end
        S_EDGE: begin
          prod <= mul_a * mul_b;
          case (step)
            2'd1:    sum_x <= acc_sat;
            2'd2:    sum_y <= acc_sat;
            2'd3:    sum_z <= acc_sat;
            default: ;
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) state <= edge_r.last_edge ? S_MAG : S_IDLE;
        end
        S_MAG: begin
          mx <= sum_x[ACC_BITS-1] ? (ACC_BITS'(0) - sum_x) : sum_x;
          my <= sum_y[ACC_BITS-1] ? (ACC_BITS'(0) - sum_y) : sum_y;
          mz <= sum_z[ACC_BITS-1] ? (ACC_BITS'(0) - sum_z) : sum_z;
          state <= S_TOP;
        end
        S_TOP: begin
          if (mx >= my && mx >= mz) top <= mx;
          else if (my >= mz)        top <= my;
          else                      top <= mz;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (top == '0) begin
            nx    <= '0;
            ny    <= '0;
            nz    <= UNIT_Z[NORMAL_BITS-1:0];
            degen <= 1'b1;
            state <= S_DONE;
          end else if (top >= TOP_HI) begin
            top <= top >> 1;
            mx  <= mx >> 1;
            my  <= my >> 1;
            mz  <= mz >> 1;
          end else if (top < TOP_LO) begin
            top <= top << 1;
            mx  <= mx << 1;
            my  <= my << 1;
            mz  <= mz << 1;
          end else begin
            sumsq <= '0;
            step  <= 2'd0;
            degen <= 1'b0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          prod <= mul_a * mul_b;
          if (step != 2'd0) sumsq <= sumsq + prod;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            sq_n   <= sumsq + prod;
            sq_r   <= '0;
            sq_bit <= ACC_BITS'(1) << (ACC_BITS - 2);
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_n >= sq_try) begin
            sq_n <= sq_n - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) state <= S_DSET;
        end
        S_DSET: begin
          // The quotient fits in OUT_FRAC + 1 bits, so the top of the
          // numerator already sits below the divisor.
          if (sq_bit == '0) begin
            len    <= sq_r[LEN_W-1:0];
            sq_bit <= ACC_BITS'(1);
            step   <= 2'd0;
          end else begin
            rem   <= REM_W'(num[NUM_W-1:Q_W]);
            dlow  <= num[Q_W-1:0];
            quo   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= (rem_sh >= REM_W'(len)) ? (rem_sh - REM_W'(len)) : rem_sh;
          dlow <= dlow << 1;
          quo  <= quo_next;
          dcnt <= dcnt + DC_W'(1);
          if (dcnt == DC_W'(OUT_FRAC)) begin
            case (step)
              2'd0:    nx <= q_signed[NORMAL_BITS-1:0];
              2'd1:    ny <= q_signed[NORMAL_BITS-1:0];
              default: nz <= q_signed[NORMAL_BITS-1:0];
            endcase
            step  <= step + 2'd1;
            state <= (step == 2'd2) ? S_DONE : S_DSET;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result.normal_x    <= nx;
            result.normal_y    <= ny;
            result.normal_z    <= nz;
            result.face_number <= face_counter;
            result.degenerate  <= degen;
            result_valid       <= 1'b1;
            sum_x              <= '0;
            sum_y              <= '0;
            sum_z              <= '0;
            face_counter       <= face_counter + FACE_INDEX_BITS'(1);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_ready = (state == S_IDLE);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while the sequencer was busy");

  a_degen_axes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.normal_x == '0 && result.normal_y == '0)
    else $error("degenerate face with non-zero x or y");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> sum_x == '0 && sum_y == '0 && sum_z == '0)
    else $error("sums not cleared when the face result was loaded");

endmodule
